### rtl/core/oll_pkg.sv
`timescale 1ns / 1ps

package oll_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int DATA_W           = 32;
    localparam int MODE_W           = 3;
    localparam int STATUS_W         = 2;
    localparam int POS_W            = 5;

    localparam logic [MODE_W-1:0] MODE_INS_FRONT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_END    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_BEFORE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INS_AFTER  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // which cells lie at or past the edit point
    localparam logic [1:0] REGION_ALL  = 2'd0;
    localparam logic [1:0] REGION_FREE = 2'd1;
    localparam logic [1:0] REGION_INCL = 2'd2;
    localparam logic [1:0] REGION_EXCL = 2'd3;

    localparam logic [1:0] WR_HOLD   = 2'd0;
    localparam logic [1:0] WR_INSERT = 2'd1;
    localparam logic [1:0] WR_REMOVE = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       apply;
        logic [1:0] region_sel;
        logic [1:0] wr_op;
    } cell_ctrl_t;

endpackage

### rtl/core/oll_if.sv
`timescale 1ns / 1ps

interface oll_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic signed [31:0] match_value;
    logic signed [31:0] new_value;

    modport source (output valid, output mode, output match_value, output new_value,
                    input ready);
    modport sink   (input valid, input mode, input match_value, input new_value,
                    output ready);
endinterface

interface oll_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [4:0] position;
    logic [4:0] entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface

### rtl/core/oll_cell.sv
`timescale 1ns / 1ps

module oll_cell
    import oll_pkg::*;
#(
    parameter int LEN_W = 5,
    parameter int INDEX = 0
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic        [LEN_W-1:0]  length,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] new_value,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic                     left_region,
    input  logic signed [DATA_W-1:0] right_value,
    input  logic                     seen_in,
    output logic signed [DATA_W-1:0] value,
    output logic                     region,
    output logic                     seen_out,
    output logic                     first
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     match_reg;
    logic                     occupied;

    assign occupied = LEN_W'(INDEX) < length;
    assign seen_out = seen_in | match_reg;
    assign first    = match_reg & ~seen_in;
    assign value    = value_reg;

    always_comb
    begin
        case (ctrl.region_sel)
            REGION_ALL:  region = 1'b1;
            REGION_FREE: region = ~occupied;
            REGION_INCL: region = seen_out;
            REGION_EXCL: region = seen_in;
            default:     region = 1'b0;
        endcase
    end

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.wr_op)
            WR_INSERT:
            begin
                if (region)
                begin
                    value_next = left_region ? left_value : new_value;
                end
            end
            WR_REMOVE:
            begin
                if (region)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.apply)
        begin
            value_reg <= value_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            match_reg <= occupied && (value_reg == key);
        end
    end

endmodule

### rtl/core/ordered_list_engine.sv
`timescale 1ns / 1ps

// ordered list of up to CAPACITY signed 32-bit values held in a row of cells, one value
// per cell in list order, empty after reset. each request word is handled in steps: in the
// accept cycle each cell compares its value with the key and registers the match; then,
// once no earlier response waits untaken, a one-bit chain through the cells picks the first
// match and every cell loads its own value, its left or right neighbor's value, or the new
// value, and the response word is registered. a new request is taken in the cycle after a
// response is made, even while that response waits on the output; the engine holds a
// request only while the previous response has not been taken.

module ordered_list_engine
    import oll_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    oll_req_if.sink   req,
    oll_rsp_if.source rsp
);

    localparam int LEN_W = $clog2(CAPACITY + 1);

    logic                     busy_reg;
    logic                     busy_next;
    logic [MODE_W-1:0]        mode_reg;
    logic signed [DATA_W-1:0] new_value_reg;
    logic [LEN_W-1:0]         length_reg;
    logic [LEN_W-1:0]         length_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic [POS_W-1:0]         position_reg;
    logic [POS_W-1:0]         position_next;
    logic [POS_W-1:0]         count_reg;

    logic                     accept;
    logic                     fire;
    logic                     full;
    logic                     found;
    logic [POS_W-1:0]         hit_pos;
    cell_ctrl_t               ctrl;
    logic [1:0]               region_sel;
    logic [1:0]               wr_op;

    logic signed [DATA_W-1:0] value_w  [CAPACITY];
    logic                     region_w [CAPACITY];
    logic                     first_w  [CAPACITY];
    logic                     seen_w   [CAPACITY+1];

    assign req.ready       = ~busy_reg;
    assign accept          = req.valid & ~busy_reg;
    assign fire            = busy_reg & (~out_valid_reg | rsp.ready);
    assign full            = length_reg == LEN_W'(CAPACITY);
    assign found           = seen_w[CAPACITY];
    assign seen_w[0]       = 1'b0;

    assign ctrl.capture    = accept;
    assign ctrl.apply      = fire;
    assign ctrl.region_sel = region_sel;
    assign ctrl.wr_op      = fire ? wr_op : WR_HOLD;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            oll_cell #(
                .LEN_W (LEN_W),
                .INDEX (g)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .length      (length_reg),
                .key         (req.match_value),
                .new_value   (new_value_reg),
                .left_value  ((g == 0) ? new_value_reg : value_w[(g == 0) ? 0 : g-1]),
                .left_region ((g == 0) ? 1'b0 : region_w[(g == 0) ? 0 : g-1]),
                .right_value (value_w[(g == CAPACITY-1) ? g : g+1]),
                .seen_in     (seen_w[g]),
                .value       (value_w[g]),
                .region      (region_w[g]),
                .seen_out    (seen_w[g+1]),
                .first       (first_w[g])
            );
        end
    endgenerate

    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_w[i])
            begin
                hit_pos = hit_pos | POS_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        status_next   = ST_DONE;
        position_next = '0;
        length_next   = length_reg;
        region_sel    = REGION_ALL;
        wr_op         = WR_HOLD;
        case (mode_reg)
            MODE_INS_FRONT, MODE_INS_END:
            begin
                region_sel = (mode_reg == MODE_INS_FRONT) ? REGION_ALL : REGION_FREE;
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_op       = WR_INSERT;
                    length_next = length_reg + LEN_W'(1);
                end
            end
            MODE_INS_BEFORE, MODE_INS_AFTER:
            begin
                region_sel = (mode_reg == MODE_INS_BEFORE) ? REGION_INCL : REGION_EXCL;
                if (!found)
                begin
                    status_next = ST_MISS;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_op       = WR_INSERT;
                    length_next = length_reg + LEN_W'(1);
                end
            end
            MODE_DELETE:
            begin
                region_sel = REGION_INCL;
                if (!found)
                begin
                    status_next = ST_MISS;
                end
                else
                begin
                    wr_op       = WR_REMOVE;
                    length_next = length_reg - LEN_W'(1);
                end
            end
            MODE_SEARCH:
            begin
                if (!found)
                begin
                    status_next = ST_MISS;
                end
                else
                begin
                    position_next = hit_pos;
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            length_reg    <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                length_reg <= length_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg      <= req.mode;
            new_value_reg <= req.new_value;
        end
        if (fire)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
            count_reg    <= POS_W'(length_next);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.position    = position_reg;
    assign rsp.entry_count = count_reg;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted word not held for processing");

    a_rsp_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg))
        else $error("response without a pending request");

    a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(fire) |-> $stable(length_reg))
        else $error("list length changed outside an update");
`endif

endmodule

### tb/tb_ordered_list_engine.sv
`timescale 1ns / 1ps

module tb_ordered_list_engine;
    import oll_pkg::*;

    localparam int          CAP         = DEFAULT_CAPACITY;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          RANDOM_WORDS = 700;
    localparam int          NUM_ROWS    = 22;
    localparam int          REPORT_MAX  = 10;

    localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

    localparam logic [31:0] V_MIN  = 32'h8000_0000;
    localparam logic [31:0] V_MAX  = 32'h7fff_ffff;
    localparam logic [31:0] V_NEG1 = 32'hffff_ffff;
    localparam logic [31:0] V_ZERO = 32'h0000_0000;
    localparam logic [31:0] V_ODD  = 32'd12345;

    localparam int BIAS_FILL  = 0;
    localparam int BIAS_DRAIN = 1;
    localparam int BIAS_MIXED = 2;

    localparam logic [MODE_W-1:0] MODE_BY_SLOT [6] = '{MODE_INS_FRONT, MODE_INS_END,
        MODE_INS_BEFORE, MODE_INS_AFTER, MODE_DELETE, MODE_SEARCH};
    localparam int MODE_WEIGHT [3][6] = '{'{27, 25, 15, 15, 8, 7},
                                          '{7, 7, 5, 5, 48, 25},
                                          '{16, 16, 16, 16, 16, 17}};

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [31:0]       key;
        logic [31:0]       val;
    } list_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    count;
    } list_rsp_t;

    typedef struct packed {
        list_req_t word;
        logic      typed;
        list_rsp_t want;
    } list_row_t;

    logic clk;
    logic rst_n;

    oll_req_if req ();
    oll_rsp_if rsp ();

    ordered_list_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    logic [31:0] shadow_list [CAP];
    int          shadow_len;
    list_rsp_t   expected_q [$];
    list_row_t   plan [NUM_ROWS];
    int          mismatches;
    int          cycles = 0;
    bit          src_burst;
    bit          snk_burst;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic list_rsp_t apply_list_op(input list_req_t w);
        list_rsp_t r;
        int        hit;
        int        at;
        bit        do_ins;
        r.status   = ST_DONE;
        r.position = '0;
        hit        = -1;
        at         = 0;
        do_ins     = 1'b0;
        for (int i = shadow_len - 1; i >= 0; i--)
        begin
            if (shadow_list[i] == w.key)
                hit = i;
        end
        case (w.mode)
            MODE_INS_FRONT, MODE_INS_END:
            begin
                if (shadow_len >= CAP)
                    r.status = ST_FULL;
                else
                begin
                    do_ins = 1'b1;
                    at     = (w.mode == MODE_INS_FRONT) ? 0 : shadow_len;
                end
            end
            MODE_INS_BEFORE, MODE_INS_AFTER:
            begin
                if (hit < 0)
                    r.status = ST_MISS;
                else if (shadow_len >= CAP)
                    r.status = ST_FULL;
                else
                begin
                    do_ins = 1'b1;
                    at     = (w.mode == MODE_INS_BEFORE) ? hit : hit + 1;
                end
            end
            MODE_DELETE:
            begin
                if (hit < 0)
                    r.status = ST_MISS;
                else
                begin
                    for (int i = hit; i < shadow_len - 1; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
            MODE_SEARCH:
            begin
                if (hit < 0)
                    r.status = ST_MISS;
                else
                    r.position = POS_W'(hit + 1);
            end
            default:
            begin
            end
        endcase
        if (do_ins)
        begin
            for (int i = shadow_len; i > at; i--)
                shadow_list[i] = shadow_list[i-1];
            shadow_list[at] = w.val;
            shadow_len++;
        end
        r.count = POS_W'(shadow_len);
        return r;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 7)) - 32'd4;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return V_MIN;
                    1: return V_MAX;
                    2: return V_NEG1;
                    default: return V_ZERO;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic list_req_t random_word(input int bias);
        list_req_t w;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            w.mode = (pick == 0) ? MODE_UNUSED_6 : MODE_UNUSED_7;
        else
        begin
            pick   = pick - 3;
            w.mode = MODE_SEARCH;
            for (int i = 0; i < 6; i++)
            begin
                if (pick >= 0 && pick < MODE_WEIGHT[bias][i])
                    w.mode = MODE_BY_SLOT[i];
                pick = pick - MODE_WEIGHT[bias][i];
            end
        end
        if (shadow_len > 0 && $urandom_range(0, 3) != 0)
            w.key = shadow_list[$urandom_range(0, shadow_len - 1)];
        else
            w.key = random_value();
        w.val = random_value();
        return w;
    endfunction

    task automatic send_word(input list_req_t w, input logic typed, input list_rsp_t want);
        int        gap;
        list_rsp_t predicted;
        gap = src_burst ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 15) == 0)
            src_burst = !src_burst;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.mode        <= w.mode;
        req.match_value <= w.key;
        req.new_value   <= w.val;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predicted = apply_list_op(w);
        expected_q.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int seg_left;
        int bias;
        int sent;
        mismatches  = 0;
        shadow_len  = 0;
        src_burst   = 1'b0;
        for (int i = 0; i < CAP; i++)
            shadow_list[i] = '0;
        rst_n           <= 1'b0;
        req.valid       <= 1'b0;
        req.mode        <= MODE_INS_FRONT;
        req.match_value <= '0;
        req.new_value   <= '0;

        plan = '{
            '{'{MODE_SEARCH,     V_ZERO, V_ZERO}, 1'b1, '{ST_MISS, 5'd0, 5'd0}},
            '{'{MODE_DELETE,     V_ZERO, V_ZERO}, 1'b1, '{ST_MISS, 5'd0, 5'd0}},
            '{'{MODE_INS_BEFORE, V_ZERO, 32'd1},  1'b1, '{ST_MISS, 5'd0, 5'd0}},
            '{'{MODE_INS_AFTER,  V_ZERO, 32'd1},  1'b1, '{ST_MISS, 5'd0, 5'd0}},
            '{'{MODE_INS_FRONT,  V_ZERO, V_MIN},  1'b1, '{ST_DONE, 5'd0, 5'd1}},
            '{'{MODE_INS_END,    V_ZERO, V_MAX},  1'b1, '{ST_DONE, 5'd0, 5'd2}},
            '{'{MODE_UNUSED_6,   V_MAX,  V_MIN},  1'b1, '{ST_DONE, 5'd0, 5'd2}},
            '{'{MODE_UNUSED_7,   V_NEG1, V_NEG1}, 1'b1, '{ST_DONE, 5'd0, 5'd2}},
            '{'{MODE_SEARCH,     V_MAX,  V_ZERO}, 1'b1, '{ST_DONE, 5'd2, 5'd2}},
            '{'{MODE_SEARCH,     V_MIN,  V_ZERO}, 1'b1, '{ST_DONE, 5'd1, 5'd2}},
            '{'{MODE_SEARCH,     V_NEG1, V_ZERO}, 1'b1, '{ST_MISS, 5'd0, 5'd2}},
            '{'{MODE_INS_BEFORE, V_MIN,  V_NEG1}, 1'b0, '0},
            '{'{MODE_INS_AFTER,  V_MAX,  V_ZERO}, 1'b0, '0},
            '{'{MODE_INS_AFTER,  V_NEG1, V_NEG1}, 1'b0, '0},
            '{'{MODE_SEARCH,     V_NEG1, V_ZERO}, 1'b0, '0},
            '{'{MODE_DELETE,     V_NEG1, V_ZERO}, 1'b0, '0},
            '{'{MODE_SEARCH,     V_NEG1, V_ZERO}, 1'b0, '0},
            '{'{MODE_DELETE,     V_ODD,  V_ZERO}, 1'b0, '0},
            '{'{MODE_INS_BEFORE, V_ODD,  32'd5},  1'b0, '0},
            '{'{MODE_DELETE,     V_MIN,  V_ZERO}, 1'b0, '0},
            '{'{MODE_DELETE,     V_MAX,  V_ZERO}, 1'b0, '0},
            '{'{MODE_SEARCH,     V_ZERO, V_ZERO}, 1'b0, '0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_word(plan[i].word, plan[i].typed, plan[i].want);
        drain_results();

        // fill first so the full-list cases come early
        bias     = BIAS_FILL;
        seg_left = 40;
        sent     = 0;
        while (sent < RANDOM_WORDS)
        begin
            send_word(random_word(bias), 1'b0, '0);
            sent++;
            seg_left--;
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 60);
                bias     = $urandom_range(BIAS_FILL, BIAS_MIXED);
                if ($urandom_range(0, 2) == 0)
                    drain_results();
            end
        end

        req.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int        gap;
        list_rsp_t want;
        list_rsp_t seen;
        snk_burst = 1'b0;
        rsp.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            gap = snk_burst ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 15) == 0)
                snk_burst = !snk_burst;
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (rsp.valid !== 1'b1)
                @(posedge clk);
            seen = '{rsp.status, rsp.position, rsp.entry_count};
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected word: status %0d position %0d count %0d",
                             seen.status, seen.position, seen.count);
            end
            else
            begin
                want = expected_q.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: status %0d/%0d position %0d/%0d count %0d/%0d",
                                 want.status, seen.status, want.position, seen.position,
                                 want.count, seen.count);
                end
            end
        end
    end

endmodule

### sim.f
rtl/core/oll_pkg.sv
rtl/core/oll_if.sv
rtl/core/oll_cell.sv
rtl/core/ordered_list_engine.sv
tb/tb_ordered_list_engine.sv
